/* src/lsm_pkg.sv */
`timescale 1ns / 1ps
// Package for the linked stack manager: sizes, operation codes and item types.
// No dependencies.
package lsm_pkg;

  localparam int ITEM_COUNT   = 256;
  localparam int ITEM_W       = 8;
  localparam int VERSION_BITS = 16;
  localparam int ADDR_W       = $clog2(ITEM_COUNT);
  localparam int STEP_W       = $clog2(ITEM_COUNT) + 1;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_POP_ALL = 2'd2,
    FUNC_REMOVE  = 2'd3
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [ITEM_W-1:0] item;
  } in_item_t;

  typedef struct packed {
    logic [ITEM_W-1:0] result_item;
    logic              success;
    logic              empty_after;
  } out_item_t;

  function automatic logic item_ok(input logic [ITEM_W-1:0] idx);
    item_ok = (idx != '0) && (int'(idx) < ITEM_COUNT);
  endfunction

endpackage

/* src/lsm_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module lsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/linked_stack_manager.sv */
`timescale 1ns / 1ps
// Top level of the linked stack manager: control sequencer and link memory.
// Depends on lsm_pkg and lsm_ram.

// The stack is a chain of item indices in a single-port-pair link memory, each
// entry holding the index of the item below it, with index 0 meaning none.
// One item is worked on at a time. Push, pop, pop-all and a remove of the top
// item pass through the accept step, which reads the head's link, and the
// execute step, which waits for a free output register. A remove below the
// top walks the chain one link read per cycle while the output register is
// free, then splices with one read and two writes. A finished result waits
// in an output register while the next item is accepted. The link memory
// needs no clearing after reset.
module linked_stack_manager
  import lsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_SPLICE,
    ST_CLEAR
  } state_t;

  state_t                  state_r, state_nxt;
  func_t                   func_r, func_nxt;
  logic [ITEM_W-1:0]       item_r, item_nxt;
  logic [ITEM_W-1:0]       head_r, head_nxt;
  logic [VERSION_BITS-1:0] version_r, version_nxt;
  logic [ITEM_W-1:0]       cur_r, cur_nxt;
  logic [STEP_W-1:0]       steps_r, steps_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ITEM_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ITEM_W-1:0] ram_rdata;

  logic              out_free;
  logic              do_emit;
  logic              do_take;
  logic              do_walk;
  logic [STEP_W-1:0] steps_inc;
  out_item_t         emit_data;

  lsm_ram #(
    .WIDTH(ITEM_W),
    .DEPTH(ITEM_COUNT)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign steps_inc = steps_r + STEP_W'(1);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    item_nxt      = item_r;
    head_nxt      = head_r;
    version_nxt   = version_r;
    cur_nxt       = cur_r;
    steps_nxt     = steps_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = ADDR_W'(item_r);
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = ADDR_W'(head_r);
    do_emit       = 1'b0;
    do_take       = 1'b0;
    do_walk       = 1'b0;
    emit_data     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_data.func;
          item_nxt  = in_data.item;
          cur_nxt   = head_r;
          steps_nxt = '0;
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(head_r);
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          case (func_r)
            FUNC_PUSH: begin
              do_emit = 1'b1;
              if (item_ok(item_r)) begin
                ram_we            = 1'b1;
                ram_waddr         = ADDR_W'(item_r);
                ram_wdata         = head_r;
                head_nxt          = item_r;
                emit_data.success = 1'b1;
              end
            end
            FUNC_POP: begin
              if (head_r != '0) begin
                do_take = 1'b1;
              end else begin
                do_emit = 1'b1;
              end
            end
            FUNC_POP_ALL: begin
              do_emit = 1'b1;
              if (head_r != '0) begin
                emit_data.result_item = head_r;
                emit_data.success     = 1'b1;
                head_nxt              = '0;
                version_nxt           = version_r + VERSION_BITS'(1);
              end
            end
            FUNC_REMOVE: begin
              if (!item_ok(item_r) || head_r == '0) begin
                do_emit = 1'b1;
              end else if (head_r == item_r) begin
                do_take = 1'b1;
              end else begin
                do_walk = 1'b1;
              end
            end
            default: begin
              do_emit = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        if (out_free) begin
          do_walk = 1'b1;
        end
      end
      ST_SPLICE: begin
        ram_we    = 1'b1;
        ram_waddr = ADDR_W'(cur_r);
        ram_wdata = ram_rdata;
        state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (out_free) begin
          ram_we                = 1'b1;
          ram_waddr             = ADDR_W'(item_r);
          ram_wdata             = '0;
          do_emit               = 1'b1;
          emit_data.result_item = item_r;
          emit_data.success     = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (do_take) begin
      ram_we                = 1'b1;
      ram_waddr             = ADDR_W'(head_r);
      ram_wdata             = '0;
      head_nxt              = ram_rdata;
      version_nxt           = version_r + VERSION_BITS'(1);
      emit_data.result_item = head_r;
      emit_data.success     = 1'b1;
      do_emit               = 1'b1;
    end

    if (do_walk) begin
      if (ram_rdata == item_r) begin
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(item_r);
        state_nxt = ST_SPLICE;
      end else if (ram_rdata == '0 || steps_inc == STEP_W'(ITEM_COUNT)) begin
        do_emit = 1'b1;
      end else begin
        cur_nxt   = ram_rdata;
        steps_nxt = steps_inc;
        ram_re    = 1'b1;
        ram_raddr = ADDR_W'(ram_rdata);
        state_nxt = ST_WALK;
      end
    end

    if (do_emit) begin
      emit_data.empty_after = (head_nxt == '0);
      out_valid_nxt         = 1'b1;
      out_data_nxt          = emit_data;
      state_nxt             = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      version_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      version_r   <= version_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r     <= func_nxt;
    item_r     <= item_nxt;
    cur_r      <= cur_nxt;
    steps_r    <= steps_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

/* src/lsm_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the linked stack manager, bound to the top level.
// Depends on lsm_pkg and linked_stack_manager.
module lsm_checker
  import lsm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A result waiting for the consumer stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // A failed operation returns no item.
  a_fail_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.success |-> out_data.result_item == '0)
    else $error("failed operation returned an item");

  // No result is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind linked_stack_manager lsm_checker u_lsm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
